/* hdl/binomial_coefficient_assert.svh */
// Assertion macros for the binomial coefficient block.
`ifndef BINOMIAL_COEFFICIENT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_ASSERT_SVH

`ifndef SYNTHESIS

`define BC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bc assertion failed: same-cycle implication");

`define BC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bc assertion failed: next-cycle implication");

`else

`define BC_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define BC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/bc_pkg.sv */
package bc_pkg;

   localparam int N_BITS    = 16;
   localparam int IN_W      = 16;
   localparam int OPND_W    = (N_BITS < IN_W) ? N_BITS : IN_W;
   localparam int COUNT_W   = 63;
   localparam int PROD_W    = COUNT_W + OPND_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);
   localparam int STEP_W    = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_MUL,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_SAT,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_TRIVIAL,
      COND_OVF,
      COND_DIV_BUSY,
      COND_MORE,
      COND_OUT_BUSY
   } cond_type;

   localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_SETUP = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_MUL   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_CHECK = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_DIV   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_NEXT  = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_SAT   = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_SAT;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic trivial;
      logic ovf;
      logic div_busy;
      logic more;
      logic out_busy;
   } status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      case (addr)
         STEP_IDLE:  w = '{op: OP_LOAD,     cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_SETUP: w = '{op: OP_SETUP,    cond: COND_TRIVIAL,  target: STEP_WAIT};
         STEP_MUL:   w = '{op: OP_MUL,      cond: COND_NEVER,    target: STEP_IDLE};
         STEP_CHECK: w = '{op: OP_DIV_INIT, cond: COND_OVF,      target: STEP_SAT};
         STEP_DIV:   w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: STEP_DIV};
         STEP_NEXT:  w = '{op: OP_UPDATE,   cond: COND_MORE,     target: STEP_MUL};
         STEP_WAIT:  w = '{op: OP_NONE,     cond: COND_OUT_BUSY, target: STEP_WAIT};
         STEP_EMIT:  w = '{op: OP_EMIT,     cond: COND_ALWAYS,   target: STEP_IDLE};
         STEP_SAT:   w = '{op: OP_SAT,      cond: COND_ALWAYS,   target: STEP_WAIT};
         default:    w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* hdl/bc_req_if.sv */
interface bc_req_if;
   import bc_pkg::*;

   logic              valid;
   logic              ready;
   logic [IN_W-1:0]   n_total;
   logic [IN_W-1:0]   r_chosen;

   modport source (output valid, output n_total, output r_chosen, input ready);
   modport sink   (input valid, input n_total, input r_chosen, output ready);
endinterface

/* hdl/bc_rsp_if.sv */
interface bc_rsp_if;
   import bc_pkg::*;

   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  count;
   logic                overflow;

   modport source (output valid, output count, output overflow, input ready);
   modport sink   (input valid, input count, input overflow, output ready);
endinterface

/* hdl/bc_seq.sv */
module bc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  bc_pkg::status_type  status,
   output bc_pkg::ucode_type   ctrl
);
   import bc_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_valid;
         COND_TRIVIAL:  jump = status.trivial;
         COND_OVF:      jump = status.ovf;
         COND_DIV_BUSY: jump = status.div_busy;
         COND_MORE:     jump = status.more;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b1;
      endcase
      step_in = jump ? ctrl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* hdl/bc_dp.sv */
module bc_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  bc_pkg::op_type             op,
   input  logic [bc_pkg::IN_W-1:0]    n_total,
   input  logic [bc_pkg::IN_W-1:0]    r_chosen,
   input  logic                       rsp_ready,
   output bc_pkg::status_type         status,
   output logic                       rsp_valid,
   output logic [bc_pkg::COUNT_W-1:0] rsp_count,
   output logic                       rsp_overflow
);
   import bc_pkg::*;

   logic [OPND_W-1:0]    n_ff, n_in;
   logic [OPND_W-1:0]    r_ff, r_in;
   logic [OPND_W-1:0]    i_ff, i_in;
   logic [OPND_W-1:0]    factor_ff, factor_in;
   logic [COUNT_W-1:0]   acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [OPND_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   count_out_ff, count_out_in;
   logic                 ovf_out_ff, ovf_out_in;

   logic [OPND_W-1:0]    n_minus_r;
   logic                 r_above_n;
   logic                 r_above_half;
   logic [PROD_W-1:0]    mul_res;
   logic [OPND_W:0]      rem_sh;
   logic [OPND_W:0]      rem_diff;
   logic                 q_bit;

   assign n_minus_r    = n_ff - r_ff;
   assign r_above_n    = r_ff > n_ff;
   assign r_above_half = r_ff > n_minus_r;
   assign mul_res      = {{OPND_W{1'b0}}, acc_ff} * {{COUNT_W{1'b0}}, factor_ff};
   assign rem_sh       = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_diff     = rem_sh - {1'b0, i_ff};
   assign q_bit        = rem_sh >= {1'b0, i_ff};

   assign status.trivial  = r_above_n || (r_ff == '0) || (r_ff == n_ff);
   assign status.ovf      = |prod_ff[PROD_W-1:COUNT_W];
   assign status.div_busy = cnt_ff != '0;
   assign status.more     = i_ff != r_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      n_in         = n_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      factor_in    = factor_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      count_out_in = count_out_ff;
      ovf_out_in   = ovf_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (op)
         OP_LOAD: begin
            n_in = n_total[OPND_W-1:0];
            r_in = r_chosen[OPND_W-1:0];
         end
         OP_SETUP: begin
            acc_in    = r_above_n ? '0 : COUNT_W'(1);
            ovf_in    = 1'b0;
            i_in      = OPND_W'(1);
            r_in      = r_above_half ? n_minus_r : r_ff;
            factor_in = (r_above_half ? r_ff : n_minus_r) + OPND_W'(1);
         end
         OP_MUL: begin
            prod_in = mul_res;
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            cnt_in = DIV_CNT_W'(PROD_W - 1);
         end
         OP_DIV_STEP: begin
            rem_in  = q_bit ? rem_diff[OPND_W-1:0] : rem_sh[OPND_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], q_bit};
            cnt_in  = cnt_ff - DIV_CNT_W'(1);
         end
         OP_UPDATE: begin
            acc_in    = prod_ff[COUNT_W-1:0];
            i_in      = i_ff + OPND_W'(1);
            factor_in = factor_ff + OPND_W'(1);
         end
         OP_SAT: begin
            acc_in = COUNT_MAX;
            ovf_in = 1'b1;
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            count_out_in = acc_ff;
            ovf_out_in   = ovf_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      r_ff         <= r_in;
      i_ff         <= i_in;
      factor_ff    <= factor_in;
      acc_ff       <= acc_in;
      ovf_ff       <= ovf_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      count_out_ff <= count_out_in;
      ovf_out_ff   <= ovf_out_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = count_out_ff;
   assign rsp_overflow = ovf_out_ff;

endmodule

/* hdl/binomial_coefficient.sv */
// channel   dir   modport   payload
// req_chan  in    sink      n_total[15:0], r_chosen[15:0]
// rsp_chan  out   source    count[62:0], overflow
//
// One transaction at a time. An item runs k = min(r, n-r) products, or none
// when r > n, r = 0 or r = n. When product j overflows, its divide is skipped
// and the item ends early with a saturated count.
// Each product step is bound by the shared restoring divider, one quotient bit per
// cycle over the 79-bit product. Reset is synchronous, active high.
// A finished result waits in the output register while the next request is taken.
`include "binomial_coefficient_assert.svh"

module binomial_coefficient (
   input  logic       clock,
   input  logic       reset,
   bc_req_if.sink     req_chan,
   bc_rsp_if.source   rsp_chan
);
   import bc_pkg::*;

   ucode_type  ctrl;
   status_type status;

   assign req_chan.ready = ctrl.op == OP_LOAD;

   bc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   bc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (ctrl.op),
      .n_total      (req_chan.n_total),
      .r_chosen     (req_chan.r_chosen),
      .rsp_ready    (rsp_chan.ready),
      .status       (status),
      .rsp_valid    (rsp_chan.valid),
      .rsp_count    (rsp_chan.count),
      .rsp_overflow (rsp_chan.overflow)
   );

   `BC_ASSERT_IMPLY(a_sat_count, clock, reset, rsp_chan.valid && rsp_chan.overflow, rsp_chan.count == COUNT_MAX)
   `BC_ASSERT_IMPLY(a_emit_free, clock, reset, ctrl.op == OP_EMIT, !rsp_chan.valid)
   `BC_ASSERT_NEXT(a_one_item, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

endmodule
